[src/sagen_pkg.sv]
// Shared types and constants of the sensor arrival time generator.
// No dependencies; used by every module in src.
package sagen_pkg;

    localparam int MAX_SENSORS     = 32;
    localparam int COORD_FRAC_BITS = 8;
    localparam int SPEED_FRAC_BITS = 14;
    localparam int TIME_FRAC_BITS  = 8;
    localparam int DELAY_SHIFT     = COORD_FRAC_BITS + SPEED_FRAC_BITS - TIME_FRAC_BITS;

    localparam int IDX_W   = 5;
    localparam int CNT_W   = 6;
    localparam int COORD_W = 24;
    localparam int PITCH_W = 16;
    localparam int SPEED_W = 16;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 24;
    localparam int BASE_W  = 25;
    localparam int PACC_W  = 21;
    localparam int DX_W    = 26;
    localparam int AY_W    = 24;
    localparam int RAD_W   = 52;
    localparam int ROOT_W  = 26;
    localparam int REM_W   = 28;
    localparam int PROD_W  = ROOT_W + SPEED_W;
    localparam int DLY_W   = PROD_W - DELAY_SHIFT;

    typedef enum logic [1:0] {
        REG_LEFT_X    = 2'd0,
        REG_PITCH     = 2'd1,
        REG_COUNT     = 2'd2,
        REG_INV_SPEED = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] source_x;
        logic signed [COORD_W-1:0] source_y;
        logic [TIME_W-1:0]         emit_time;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]  sensor_index;
        logic [TIME_W-1:0] arrival_time;
        logic              last_sensor;
    } out_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] left_x;
        logic [PITCH_W-1:0]        pitch;
        logic [CNT_W-1:0]          count;
        logic [SPEED_W-1:0]        inv_speed;
    } cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic              last;
        logic [TIME_W-1:0] t0;
    } side_t;

endpackage

[src/sagen_seq.sv]
// Per-source sequencer: takes one source and issues one dx per sensor.
// Depends on sagen_pkg.
module sagen_seq (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  sagen_pkg::in_item_t               in_data,
    input  sagen_pkg::cfg_t                   cfg,
    output logic                              s0_vld,
    output logic signed [sagen_pkg::DX_W-1:0] s0_dx,
    output logic [sagen_pkg::AY_W-1:0]        s0_ay,
    output sagen_pkg::side_t                  s0_side
);

    logic                                busy_reg, busy_next;
    logic [sagen_pkg::IDX_W-1:0]         k_reg, k_next;
    logic [sagen_pkg::CNT_W-1:0]         n_reg, n_next;
    logic signed [sagen_pkg::BASE_W-1:0] base_reg, base_next;
    logic [sagen_pkg::PACC_W-1:0]        pacc_reg, pacc_next;
    logic [sagen_pkg::AY_W-1:0]          ay_reg, ay_next;
    logic [sagen_pkg::TIME_W-1:0]        t0_reg, t0_next;
    logic                                vld_reg, vld_next;
    logic signed [sagen_pkg::DX_W-1:0]   dx_reg, dx_next;
    logic [sagen_pkg::AY_W-1:0]          oay_reg, oay_next;
    sagen_pkg::side_t                    side_reg, side_next;

    logic                        acc;
    logic                        issue_last;
    logic [sagen_pkg::CNT_W-1:0] n_sat;

    assign acc        = in_valid && !busy_reg;
    assign in_stall   = busy_reg;
    assign n_sat      = (cfg.count > sagen_pkg::CNT_W'(sagen_pkg::MAX_SENSORS))
                        ? sagen_pkg::CNT_W'(sagen_pkg::MAX_SENSORS) : cfg.count;
    assign issue_last = (k_reg == sagen_pkg::IDX_W'(n_reg - 1'b1));

    always_comb
    begin
        busy_next = busy_reg;
        k_next    = k_reg;
        n_next    = n_reg;
        base_next = base_reg;
        pacc_next = pacc_reg;
        ay_next   = ay_reg;
        t0_next   = t0_reg;
        vld_next  = vld_reg;
        dx_next   = dx_reg;
        oay_next  = oay_reg;
        side_next = side_reg;
        if (acc)
        begin
            busy_next = (n_sat != '0);
            k_next    = '0;
            n_next    = n_sat;
            base_next = {cfg.left_x[sagen_pkg::COORD_W-1], cfg.left_x}
                      - {in_data.source_x[sagen_pkg::COORD_W-1], in_data.source_x};
            pacc_next = '0;
            ay_next   = in_data.source_y[sagen_pkg::COORD_W-1]
                        ? sagen_pkg::AY_W'(-in_data.source_y)
                        : sagen_pkg::AY_W'(in_data.source_y);
            t0_next   = in_data.emit_time;
        end
        if (adv)
        begin
            vld_next = busy_reg;
            if (busy_reg)
            begin
                dx_next        = sagen_pkg::DX_W'(base_reg)
                               + $signed({{(sagen_pkg::DX_W-sagen_pkg::PACC_W){1'b0}}, pacc_reg});
                oay_next       = ay_reg;
                side_next.idx  = k_reg;
                side_next.last = issue_last;
                side_next.t0   = t0_reg;
                k_next         = k_reg + 1'b1;
                pacc_next      = sagen_pkg::PACC_W'(pacc_reg + cfg.pitch);
                busy_next      = !issue_last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            vld_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            vld_reg  <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        n_reg    <= n_next;
        base_reg <= base_next;
        pacc_reg <= pacc_next;
        ay_reg   <= ay_next;
        t0_reg   <= t0_next;
        dx_reg   <= dx_next;
        oay_reg  <= oay_next;
        side_reg <= side_next;
    end

    assign s0_vld  = vld_reg;
    assign s0_dx   = dx_reg;
    assign s0_ay   = oay_reg;
    assign s0_side = side_reg;

`ifndef SYNTH
    a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (6'(k_reg) < n_reg))
        else $error("sensor index beyond count");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && adv && issue_last) |=> !busy_reg)
        else $error("sequencer kept running after last sensor");
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && n_sat != '0) |=> (busy_reg && k_reg == '0 && pacc_reg == '0))
        else $error("sequencer did not start at sensor zero");
`endif

endmodule

[src/sagen_sqrt.sv]
// Pipelined floored integer square root, one result bit per stage.
// Depends on sagen_pkg.
module sagen_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_vld,
    input  logic [sagen_pkg::RAD_W-1:0]   in_rad,
    input  sagen_pkg::side_t              in_side,
    output logic                          out_vld,
    output logic [sagen_pkg::ROOT_W-1:0]  out_root,
    output sagen_pkg::side_t              out_side
);

    localparam int N = sagen_pkg::ROOT_W;

    logic                         vld_reg  [N];
    logic [sagen_pkg::RAD_W-1:0]  rad_reg  [N];
    logic [sagen_pkg::REM_W-1:0]  rem_reg  [N];
    logic [sagen_pkg::ROOT_W-1:0] root_reg [N];
    sagen_pkg::side_t             side_reg [N];

    for (genvar g = 0; g < N; g++)
    begin : g_stage
        logic                           c_vld;
        logic [sagen_pkg::RAD_W-1:0]    c_rad;
        logic [sagen_pkg::REM_W-1:0]    c_rem;
        logic [sagen_pkg::ROOT_W-1:0]   c_root;
        sagen_pkg::side_t               c_side;
        logic [sagen_pkg::REM_W+1:0]    remx;
        logic [sagen_pkg::REM_W+1:0]    trial;
        logic                           take;

        if (g == 0)
        begin : g_first
            assign c_vld  = in_vld;
            assign c_rad  = in_rad;
            assign c_rem  = '0;
            assign c_root = '0;
            assign c_side = in_side;
        end
        else
        begin : g_next
            assign c_vld  = vld_reg[g-1];
            assign c_rad  = rad_reg[g-1];
            assign c_rem  = rem_reg[g-1];
            assign c_root = root_reg[g-1];
            assign c_side = side_reg[g-1];
        end

        assign remx  = {c_rem, c_rad[sagen_pkg::RAD_W-1 -: 2]};
        assign trial = {2'b00, c_root, 2'b01};
        assign take  = (remx >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[g] <= c_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rad_reg[g]  <= {c_rad[sagen_pkg::RAD_W-3:0], 2'b00};
                rem_reg[g]  <= take ? sagen_pkg::REM_W'(remx - trial)
                                    : sagen_pkg::REM_W'(remx);
                root_reg[g] <= {c_root[sagen_pkg::ROOT_W-2:0], take};
                side_reg[g] <= c_side;
            end
        end
    end

    assign out_vld  = vld_reg[N-1];
    assign out_root = root_reg[N-1];
    assign out_side = side_reg[N-1];

endmodule

[src/sensor_arrival_time_generator_core.sv]
// Sensor arrival time generator for a linear detector array.
// Takes one source (x, y, emission time) on the in channel and returns one
// arrival time per active sensor on the out channel, in sensor order, with
// last_sensor set on the final one. Both channels use valid/stall; a transfer
// happens when valid is high and stall is low. A source with a zero sensor
// count is taken and yields nothing.
// Configuration must be written through cfg_we/cfg_index/cfg_data only while
// the block is idle; the block itself does not enforce this. Writes to unknown
// indexes are dropped. Throughput: one result per cycle while out_stall does
// not hold the pipeline; a source occupies the sequencer until it has issued
// its last sensor (up to 32), and the next source transfers after that.
// Results pass through the sequencer, magnitude, square, sum, 26 root stages,
// multiply and output register.
// When out_stall is high with a result pending, the whole pipeline holds.
// Reset clears all valid bits and loads the register defaults.
// Depends on sagen_pkg, sagen_seq, sagen_sqrt.
module sensor_arrival_time_generator_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  sagen_pkg::in_item_t            in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output sagen_pkg::out_item_t           out_data,
    input  logic                           cfg_we,
    input  sagen_pkg::cfg_reg_t            cfg_index,
    input  logic [sagen_pkg::CFG_W-1:0]    cfg_data
);

    sagen_pkg::cfg_t cfg_reg;
    logic            adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left_x    <= 24'sd1920;
            cfg_reg.pitch     <= 16'd85;
            cfg_reg.count     <= 6'd30;
            cfg_reg.inv_speed <= 16'd10923;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sagen_pkg::REG_LEFT_X:    cfg_reg.left_x    <= cfg_data;
                sagen_pkg::REG_PITCH:     cfg_reg.pitch     <= cfg_data[sagen_pkg::PITCH_W-1:0];
                sagen_pkg::REG_COUNT:     cfg_reg.count     <= cfg_data[sagen_pkg::CNT_W-1:0];
                sagen_pkg::REG_INV_SPEED: cfg_reg.inv_speed <= cfg_data[sagen_pkg::SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    logic                              out_vld_reg;
    sagen_pkg::out_item_t              out_reg;

    assign adv = !out_vld_reg || !out_stall;

    logic                              s0_vld;
    logic signed [sagen_pkg::DX_W-1:0] s0_dx;
    logic [sagen_pkg::AY_W-1:0]        s0_ay;
    sagen_pkg::side_t                  s0_side;

    sagen_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .cfg      (cfg_reg),
        .s0_vld   (s0_vld),
        .s0_dx    (s0_dx),
        .s0_ay    (s0_ay),
        .s0_side  (s0_side)
    );

    logic                          s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg;
    logic [sagen_pkg::DX_W-1:0]    s1_adx_reg;
    logic [sagen_pkg::AY_W-1:0]    s1_ay_reg;
    logic [2*sagen_pkg::DX_W-1:0]  s2_xsq_reg;
    logic [2*sagen_pkg::AY_W-1:0]  s2_ysq_reg;
    logic [sagen_pkg::RAD_W-1:0]   s3_rad_reg;
    logic [sagen_pkg::PROD_W-1:0]  s4_prod_reg;
    sagen_pkg::side_t              s1_side_reg, s2_side_reg, s3_side_reg, s4_side_reg;

    logic                          r_vld;
    logic [sagen_pkg::ROOT_W-1:0]  r_root;
    sagen_pkg::side_t              r_side;

    logic [sagen_pkg::DX_W-1:0]    adx;
    logic [sagen_pkg::DLY_W-1:0]   dly;
    logic [sagen_pkg::TIME_W:0]    tsum;

    assign adx  = s0_dx[sagen_pkg::DX_W-1] ? sagen_pkg::DX_W'(-s0_dx)
                                           : sagen_pkg::DX_W'(s0_dx);
    assign dly  = s4_prod_reg[sagen_pkg::PROD_W-1:sagen_pkg::DELAY_SHIFT];
    assign tsum = {1'b0, s4_side_reg.t0} + (sagen_pkg::TIME_W+1)'(dly);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg  <= s0_vld;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= r_vld;
            out_vld_reg <= s4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_adx_reg  <= adx;
            s1_ay_reg   <= s0_ay;
            s1_side_reg <= s0_side;
            s2_xsq_reg  <= s1_adx_reg * s1_adx_reg;
            s2_ysq_reg  <= s1_ay_reg * s1_ay_reg;
            s2_side_reg <= s1_side_reg;
            s3_rad_reg  <= sagen_pkg::RAD_W'(s2_xsq_reg) + sagen_pkg::RAD_W'(s2_ysq_reg);
            s3_side_reg <= s2_side_reg;
            s4_prod_reg <= r_root * cfg_reg.inv_speed;
            s4_side_reg <= r_side;
            out_reg.sensor_index <= s4_side_reg.idx;
            out_reg.last_sensor  <= s4_side_reg.last;
            out_reg.arrival_time <= tsum[sagen_pkg::TIME_W] ? '1
                                    : tsum[sagen_pkg::TIME_W-1:0];
        end
    end

    sagen_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (s3_vld_reg),
        .in_rad   (s3_rad_reg),
        .in_side  (s3_side_reg),
        .out_vld  (r_vld),
        .out_root (r_root),
        .out_side (r_side)
    );

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

`ifndef SYNTH
    a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(s4_vld_reg) && $stable(s1_vld_reg)))
        else $error("pipeline moved while output held");
    a_first_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_reg.last_sensor && out_reg.sensor_index == '0)
            |-> (cfg_reg.count == 6'd1))
        else $error("single sensor result with wrong count");
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s4_vld_reg && tsum[sagen_pkg::TIME_W]) |=> (out_reg.arrival_time == '1))
        else $error("arrival time not saturated");
`endif

endmodule

[dv/sensor_arrival_time_generator_core_tb.sv]
`timescale 1ns / 1ps
// Testbench for sensor_arrival_time_generator_core: drives point sources and
// register settings, predicts per-sensor arrival times and checks every result.
// Depends on sagen_pkg and the core RTL in src.
module sensor_arrival_time_generator_core_tb;

    localparam int  DRAIN_CYCLES = 48;
    localparam longint CYCLE_LIMIT = 2000000;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    sagen_pkg::in_item_t           in_data;
    logic                          out_valid;
    logic                          out_stall;
    sagen_pkg::out_item_t          out_data;
    logic                          cfg_we;
    sagen_pkg::cfg_reg_t           cfg_index;
    logic [sagen_pkg::CFG_W-1:0]   cfg_data;

    sagen_pkg::cfg_t               arr_cfg;
    sagen_pkg::out_item_t          arrivals_due[$];
    int                            mismatches;
    int                            hold_left;
    bit                            quiet;
    longint                        cycles;

    sensor_arrival_time_generator_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic void predict_arrivals(sagen_pkg::in_item_t src);
        longint               dx;
        longint               sy;
        longint unsigned      adx;
        longint unsigned      ysq;
        longint unsigned      span;
        longint unsigned      t;
        int                   n;
        sagen_pkg::out_item_t r;
        n  = (arr_cfg.count > sagen_pkg::MAX_SENSORS) ? sagen_pkg::MAX_SENSORS
                                                      : int'(arr_cfg.count);
        sy = longint'($signed(src.source_y));
        ysq = (sy < 0) ? longint'(-sy) : longint'(sy);
        ysq = ysq * ysq;
        for (int k = 0; k < n; k++)
        begin
            dx = longint'($signed(arr_cfg.left_x)) - longint'($signed(src.source_x))
                 + longint'(arr_cfg.pitch) * k;
            adx = (dx < 0) ? -dx : dx;
            span = floor_root(adx * adx + ysq);
            t = longint'(src.emit_time)
                + ((span * arr_cfg.inv_speed) >> sagen_pkg::DELAY_SHIFT);
            if (t > 64'hFFFF_FFFF)
                t = 64'hFFFF_FFFF;
            r.sensor_index = k[sagen_pkg::IDX_W-1:0];
            r.arrival_time = t[sagen_pkg::TIME_W-1:0];
            r.last_sensor  = (k + 1 == n);
            arrivals_due.push_back(r);
        end
    endfunction

    // receiver: random stall, long hold on request
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall = 1'b0;
        else if (hold_left > 0)
        begin
            out_stall = 1'b1;
            hold_left--;
        end
        else
            out_stall = quiet ? 1'b0 : ($urandom_range(0, 99) < 7);
    end

    always @(posedge clk)
    begin
        sagen_pkg::out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (arrivals_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: idx %0d time %h last %b",
                             out_data.sensor_index, out_data.arrival_time,
                             out_data.last_sensor);
            end
            else
            begin
                want = arrivals_due.pop_front();
                if (out_data.sensor_index !== want.sensor_index
                    || out_data.arrival_time !== want.arrival_time
                    || out_data.last_sensor !== want.last_sensor)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp idx %0d time %h last %b, got idx %0d time %h last %b",
                                 want.sensor_index, want.arrival_time, want.last_sensor,
                                 out_data.sensor_index, out_data.arrival_time,
                                 out_data.last_sensor);
                end
            end
        end
    end

    task automatic send_source(sagen_pkg::in_item_t src);
        @(negedge clk);
        if (!quiet)
            while ($urandom_range(0, 99) < 7)
            begin
                in_valid = 1'b0;
                @(negedge clk);
            end
        in_valid = 1'b1;
        in_data  = src;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        predict_arrivals(src);
    endtask

    task automatic send_fields(logic [23:0] sx, logic [23:0] sy, logic [31:0] t0);
        sagen_pkg::in_item_t src;
        src.source_x  = sx;
        src.source_y  = sy;
        src.emit_time = t0;
        send_source(src);
    endtask

    function automatic sagen_pkg::in_item_t random_source();
        sagen_pkg::in_item_t src;
        src.source_x  = 24'($urandom());
        src.source_y  = 24'($urandom());
        src.emit_time = $urandom();
        if ($urandom_range(0, 3) != 0)
        begin
            src.source_x = 24'($urandom_range(0, 8191)) - 24'd4096;
            src.source_y = 24'($urandom_range(0, 8191)) - 24'd4096;
        end
        return src;
    endfunction

    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        wait (arrivals_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(sagen_pkg::cfg_reg_t idx, logic [sagen_pkg::CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        case (idx)
            sagen_pkg::REG_LEFT_X:    arr_cfg.left_x    = value;
            sagen_pkg::REG_PITCH:     arr_cfg.pitch     = value[sagen_pkg::PITCH_W-1:0];
            sagen_pkg::REG_COUNT:     arr_cfg.count     = value[sagen_pkg::CNT_W-1:0];
            sagen_pkg::REG_INV_SPEED: arr_cfg.inv_speed = value[sagen_pkg::SPEED_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_config(logic [23:0] lx, logic [23:0] pitch, logic [23:0] cnt,
                              logic [23:0] inv);
        settle();
        write_reg(sagen_pkg::REG_LEFT_X, lx);
        write_reg(sagen_pkg::REG_PITCH, pitch);
        write_reg(sagen_pkg::REG_COUNT, cnt);
        write_reg(sagen_pkg::REG_INV_SPEED, inv);
    endtask

    task automatic test_reset_defaults();
        send_fields(24'd0, 24'd256, 32'd0);
        send_fields(24'd1920, 24'd0, 32'd1000);
        send_fields(24'h800000, 24'h7FFFFF, 32'hFFFF_FFFF);
        send_fields(24'h7FFFFF, 24'h800000, 32'h0);
    endtask

    task automatic test_field_extremes();
        set_config(24'h800000, 24'hFFFF, 24'd32, 24'hFFFF);
        send_fields(24'h7FFFFF, 24'h7FFFFF, 32'hFFFF_FF00);
        send_fields(24'h7FFFFF, 24'h800000, 32'h0);
        send_fields(24'h800000, 24'h0, 32'h1234_5678);
        set_config(24'h7FFFFF, 24'h0, 24'd1, 24'h0);
        send_fields(24'h800000, 24'h7FFFFF, 32'hDEAD_BEEF);
        send_fields(24'h7FFFFF, 24'h0, 32'hFFFF_FFFF);
    endtask

    task automatic test_count_cases();
        set_config(24'd0, 24'd256, 24'd0, 24'd10923);
        send_fields(24'd100, 24'd200, 32'd5);
        send_fields(24'd300, 24'd0, 32'd7);
        set_config(24'hFFF000, 24'hFF1234, 24'h00003F, 24'd16384);
        send_fields(24'd0, 24'd512, 32'd0);
        send_fields(24'hFFFF00, 24'hFFFF00, 32'd99);
        set_config(24'd0, 24'd256, 24'd33, 24'hFFFFFF);
        send_fields(24'd0, 24'd0, 32'd0);
        set_config(24'd0, 24'd256, 24'd1, 24'd16384);
        send_fields(24'd0, 24'd0, 32'd0);
        send_fields(24'd768, 24'd1024, 32'd0);
    endtask

    task automatic random_config();
        logic [23:0] lx;
        logic [23:0] pitch;
        logic [23:0] cnt;
        logic [23:0] inv;
        lx    = 24'($urandom());
        pitch = 24'($urandom());
        cnt   = 24'($urandom_range(0, 63));
        inv   = 24'($urandom());
        if ($urandom_range(0, 2) != 0)
        begin
            lx    = 24'($urandom_range(0, 8191)) - 24'd4096;
            pitch = 24'($urandom_range(0, 1023));
        end
        case ($urandom_range(0, 7))
            0: cnt = 24'd0;
            1: cnt = 24'd32;
            2: inv = 24'd0;
            3: inv = 24'hFFFF;
            default: cnt = 24'($urandom_range(1, 12));
        endcase
        set_config(lx, pitch, cnt, inv);
    endtask

    task automatic test_random_sources();
        quiet = 1'b1;
        for (int i = 0; i < 315; i++)
        begin
            if (i % 25 == 0)
                random_config();
            if (i == 60)
                quiet = 1'b0;
            send_source(random_source());
        end
    endtask

    task automatic test_output_hold();
        set_config(24'd0, 24'd300, 24'd8, 24'd10923);
        @(negedge clk);
        hold_left = 300;
        for (int i = 0; i < 20; i++)
            send_source(random_source());
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = sagen_pkg::REG_LEFT_X;
        cfg_data  = '0;
        out_stall = 1'b0;
        hold_left = 0;
        quiet     = 1'b0;
        cycles    = 0;
        mismatches = 0;
        arr_cfg.left_x    = 24'd1920;
        arr_cfg.pitch     = 16'd85;
        arr_cfg.count     = 6'd30;
        arr_cfg.inv_speed = 16'd10923;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_field_extremes();
        test_count_cases();
        test_output_hold();
        test_random_sources();

        settle();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
